// ----- src/gdft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdft_pkg
// Shared types and constants of the depth-first traversal engine.
// ----------------------------------------------------------------------------
package gdft_pkg;

    localparam int MODE_W           = 2;
    localparam int VTX_W            = 6;
    localparam int CNT_W            = 7;
    localparam int STATUS_W         = 3;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 8;

    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VISITED = 3'd0,
        ST_STORED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_RANGE   = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_CLR,
        S_VCLR,
        S_SEL,
        S_SELCHK,
        S_TOP,
        S_TOPW,
        S_DEG,
        S_SCAN,
        S_NB,
        S_VIS,
        S_NEXT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic deg_we;
        logic nb_we;
    } adj_ctl_t;

    typedef struct packed {
        logic vis_we;
        logic vis_wdata;
        logic push;
        logic pop;
    } walk_ctl_t;

endpackage

// ----- src/gdft_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdft_req_if / gdft_rsp_if
// Valid/ready channels for requests and results of the traversal engine.
// ----------------------------------------------------------------------------
interface gdft_req_if
    import gdft_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [VTX_W-1:0]  source_vertex;
    logic [VTX_W-1:0]  target_vertex;

    modport source (output valid, output mode, output source_vertex,
                    output target_vertex, input ready);
    modport sink (input valid, input mode, input source_vertex,
                  input target_vertex, output ready);
endinterface

interface gdft_rsp_if
    import gdft_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VTX_W-1:0]    visited_vertex;
    logic                component_end;
    logic                last_result;

    modport source (output valid, output status, output visited_vertex,
                    output component_end, output last_result, input ready);
    modport sink (input valid, input status, input visited_vertex,
                  input component_end, input last_result, output ready);
endinterface

// ----- src/graph_depth_first_traversal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_depth_first_traversal
// Loads a directed adjacency list and walks it depth first, vertex by vertex.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready), results leave on rsp (valid/ready);
// cfg_we/cfg_wdata set vertex_count; the user must write it only while the
// engine is idle, which the block itself does not enforce.
// Add edge: one result, loaded from the edge state once the result register
//   is free; a new request is taken only after the engine is back in idle.
// Clear: sweeps every entry of the list-length table, then one result.
// Run: clears the visited map over n entries (n = effective vertex count),
//   then walks from each start vertex, scanning lists entry by entry; one
//   result per vertex. The single-port tables and this scan set the pace.
// A request is taken only while idle. One result is held back during a run
// so component_end and last_result can be marked on it.
// After reset the engine sweeps the list-length table with ready low;
// configuration writes are taken meanwhile.
// A stalled receiver freezes the engine at its next result; nothing is lost.
// ----------------------------------------------------------------------------
module graph_depth_first_traversal
    import gdft_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata,
    gdft_req_if.sink          req,
    gdft_rsp_if.source        rsp
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] vc_reg;
    logic [VW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             clr_cmd_reg, clr_cmd_next;
    logic [VTX_W-1:0] src_reg, src_next;
    logic [VTX_W-1:0] dst_reg, dst_next;
    logic [VW-1:0]    start_reg, start_next;
    logic [VW-1:0]    top_reg, top_next;
    logic [DW-1:0]    deg_reg, deg_next;
    logic [DW-1:0]    j_reg, j_next;
    logic [VW-1:0]    nb_reg, nb_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [VW-1:0]    pend_vertex_reg, pend_vertex_next;
    logic             pend_comp_reg, pend_comp_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [VW-1:0]    out_vertex_reg, out_vertex_next;
    logic             out_comp_reg, out_comp_next;
    logic             out_last_reg, out_last_next;
    logic             out_load;
    logic             out_free;
    logic             visit_ok;

    logic [CW-1:0]    n_eff;
    logic             src_ok;
    logic             dst_ok;

    adj_ctl_t         adj_ctl;
    logic [VW-1:0]    deg_addr;
    logic [DW-1:0]    deg_wdata;
    logic [DW-1:0]    deg_rdata;
    logic [VW-1:0]    nb_vertex;
    logic [SW-1:0]    nb_slot;
    logic [VW-1:0]    nb_wdata;
    logic [VW-1:0]    nb_rdata;

    walk_ctl_t        walk_ctl;
    logic [VW-1:0]    vis_addr;
    logic             vis_rdata;
    logic [VW-1:0]    stk_wdata;
    logic [VW-1:0]    stk_rdata;
    logic [CW-1:0]    stk_depth;

    gdft_adj #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_adj (
        .clk       (clk),
        .ctl       (adj_ctl),
        .deg_addr  (deg_addr),
        .deg_wdata (deg_wdata),
        .deg_rdata (deg_rdata),
        .nb_vertex (nb_vertex),
        .nb_slot   (nb_slot),
        .nb_wdata  (nb_wdata),
        .nb_rdata  (nb_rdata)
    );

    gdft_walk #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (walk_ctl),
        .vis_addr  (vis_addr),
        .vis_rdata (vis_rdata),
        .stk_wdata (stk_wdata),
        .stk_rdata (stk_rdata),
        .stk_depth (stk_depth)
    );

    // count 0 acts as 1, counts above MAX_VERTICES saturate
    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (NW'(vc_reg) > NW'(MAX_VERTICES))
        begin
            n_eff = CW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CW'(vc_reg);
        end
    end

    assign src_ok   = NW'(src_reg) < NW'(n_eff);
    assign dst_ok   = NW'(dst_reg) < NW'(n_eff);
    assign out_free = !out_valid_reg || rsp.ready;
    assign visit_ok = !pend_valid_reg || out_free;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.visited_vertex = VTX_W'(out_vertex_reg);
    assign rsp.component_end  = out_comp_reg;
    assign rsp.last_result    = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_cmd_next     = clr_cmd_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        start_next       = start_reg;
        top_next         = top_reg;
        deg_next         = deg_reg;
        j_next           = j_reg;
        nb_next          = nb_reg;
        pend_valid_next  = pend_valid_reg;
        pend_vertex_next = pend_vertex_reg;
        pend_comp_next   = pend_comp_reg;

        out_load         = 1'b0;
        out_status_next  = ST_VISITED;
        out_vertex_next  = '0;
        out_comp_next    = 1'b0;
        out_last_next    = 1'b0;

        adj_ctl          = '0;
        walk_ctl         = '0;
        deg_addr         = top_reg;
        deg_wdata        = '0;
        nb_vertex        = top_reg;
        nb_slot          = SW'(j_reg);
        nb_wdata         = VW'(dst_reg);
        vis_addr         = nb_reg;
        stk_wdata        = nb_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                deg_addr = VW'(req.source_vertex);
                if (req.valid)
                begin
                    src_next     = req.source_vertex;
                    dst_next     = req.target_vertex;
                    clr_cnt_next = '0;
                    case (mode_t'(req.mode))
                        MODE_ADD:   state_next = S_EDGE;
                        MODE_RUN:   state_next = S_VCLR;
                        MODE_CLEAR:
                        begin
                            clr_cmd_next = 1'b1;
                            state_next   = S_CLR;
                        end
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            S_EDGE:
            begin
                deg_addr  = VW'(src_reg);
                deg_wdata = deg_rdata + DW'(1);
                nb_vertex = VW'(src_reg);
                nb_slot   = SW'(deg_rdata);
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (!src_ok || !dst_ok)
                    begin
                        out_status_next = ST_RANGE;
                    end
                    else if (deg_rdata >= DW'(MAX_DEGREE))
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        out_status_next = ST_STORED;
                        adj_ctl.deg_we  = 1'b1;
                        adj_ctl.nb_we   = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_CLR:
            begin
                deg_addr       = clr_cnt_reg;
                adj_ctl.deg_we = 1'b1;
                if (clr_cnt_reg == VW'(MAX_VERTICES - 1))
                begin
                    if (!clr_cmd_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_status_next = ST_CLEARED;
                        out_last_next   = 1'b1;
                        clr_cmd_next    = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + VW'(1);
                end
            end

            S_VCLR:
            begin
                vis_addr        = clr_cnt_reg;
                walk_ctl.vis_we = 1'b1;
                if (CW'(clr_cnt_reg) + CW'(1) == n_eff)
                begin
                    start_next = '0;
                    state_next = S_SEL;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + VW'(1);
                end
            end

            S_SEL:
            begin
                vis_addr   = start_reg;
                state_next = S_SELCHK;
            end

            S_SELCHK:
            begin
                vis_addr  = start_reg;
                stk_wdata = start_reg;
                if (vis_rdata)
                begin
                    state_next = S_NEXT;
                end
                else if (visit_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load        = 1'b1;
                        out_vertex_next = pend_vertex_reg;
                        out_comp_next   = pend_comp_reg;
                    end
                    pend_valid_next    = 1'b1;
                    pend_vertex_next   = start_reg;
                    pend_comp_next     = 1'b0;
                    walk_ctl.vis_we    = 1'b1;
                    walk_ctl.vis_wdata = 1'b1;
                    walk_ctl.push      = 1'b1;
                    state_next         = S_TOP;
                end
            end

            S_TOP:
            begin
                state_next = S_TOPW;
            end

            S_TOPW:
            begin
                deg_addr   = stk_rdata;
                top_next   = stk_rdata;
                state_next = S_DEG;
            end

            S_DEG:
            begin
                deg_next   = deg_rdata;
                j_next     = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (j_reg < deg_reg)
                begin
                    state_next = S_NB;
                end
                else
                begin
                    walk_ctl.pop = 1'b1;
                    if (stk_depth == CW'(1))
                    begin
                        pend_comp_next = 1'b1;
                        state_next     = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_TOP;
                    end
                end
            end

            S_NB:
            begin
                vis_addr = nb_rdata;
                nb_next  = nb_rdata;
                if (CW'(nb_rdata) < n_eff)
                begin
                    state_next = S_VIS;
                end
                else
                begin
                    j_next     = j_reg + DW'(1);
                    state_next = S_SCAN;
                end
            end

            S_VIS:
            begin
                if (vis_rdata)
                begin
                    j_next     = j_reg + DW'(1);
                    state_next = S_SCAN;
                end
                else if (visit_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        out_load        = 1'b1;
                        out_vertex_next = pend_vertex_reg;
                        out_comp_next   = pend_comp_reg;
                    end
                    pend_valid_next    = 1'b1;
                    pend_vertex_next   = nb_reg;
                    pend_comp_next     = 1'b0;
                    walk_ctl.vis_we    = 1'b1;
                    walk_ctl.vis_wdata = 1'b1;
                    walk_ctl.push      = 1'b1;
                    state_next         = S_TOP;
                end
            end

            S_NEXT:
            begin
                if (CW'(start_reg) + CW'(1) == n_eff)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    start_next = start_reg + VW'(1);
                    state_next = S_SEL;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_vertex_next = pend_vertex_reg;
                    out_comp_next   = pend_comp_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            vc_reg         <= COUNT_RESET;
            clr_cnt_reg    <= '0;
            clr_cmd_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_cmd_reg    <= clr_cmd_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        start_reg       <= start_next;
        top_reg         <= top_next;
        deg_reg         <= deg_next;
        j_reg           <= j_next;
        nb_reg          <= nb_next;
        pend_vertex_reg <= pend_vertex_next;
        pend_comp_reg   <= pend_comp_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_vertex_reg <= out_vertex_next;
            out_comp_reg   <= out_comp_next;
            out_last_reg   <= out_last_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !out_load)
        else $error("result register overwritten while stalled");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_depth <= n_eff)
        else $error("walk stack deeper than vertex count");

    a_stack_empty_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (stk_depth == '0))
        else $error("walk stack not empty at end of run");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == S_IDLE))
        else $error("engine busy after final result");
`endif

endmodule

// ----- src/gdft_adj.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdft_adj
// Adjacency store: per-vertex list length and the neighbour table.
// ----------------------------------------------------------------------------
module gdft_adj
    import gdft_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic                            clk,
    input  adj_ctl_t                        ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0] deg_addr,
    input  logic [$clog2(MAX_DEGREE+1)-1:0] deg_wdata,
    output logic [$clog2(MAX_DEGREE+1)-1:0] deg_rdata,
    input  logic [$clog2(MAX_VERTICES)-1:0] nb_vertex,
    input  logic [((MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1)-1:0] nb_slot,
    input  logic [$clog2(MAX_VERTICES)-1:0] nb_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0] nb_rdata
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DW    = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int AW    = $clog2(DEPTH);

    logic [DW-1:0] deg_mem [MAX_VERTICES];
    logic [VW-1:0] nb_mem  [DEPTH];
    logic [DW-1:0] deg_rdata_reg;
    logic [VW-1:0] nb_rdata_reg;
    logic [AW-1:0] nb_addr;

    // row-major: vertex * MAX_DEGREE + slot
    assign nb_addr = AW'(AW'(nb_vertex) * AW'(MAX_DEGREE) + AW'(nb_slot));

    always_ff @(posedge clk)
    begin
        if (ctl.deg_we)
        begin
            deg_mem[deg_addr] <= deg_wdata;
        end
        deg_rdata_reg <= deg_mem[deg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.nb_we)
        begin
            nb_mem[nb_addr] <= nb_wdata;
        end
        nb_rdata_reg <= nb_mem[nb_addr];
    end

    assign deg_rdata = deg_rdata_reg;
    assign nb_rdata  = nb_rdata_reg;

endmodule

// ----- src/gdft_walk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdft_walk
// Walk state: visited map and the vertex stack with its depth pointer.
// ----------------------------------------------------------------------------
module gdft_walk
    import gdft_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  walk_ctl_t                         ctl,
    input  logic [$clog2(MAX_VERTICES)-1:0]   vis_addr,
    output logic                              vis_rdata,
    input  logic [$clog2(MAX_VERTICES)-1:0]   stk_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0]   stk_rdata,
    output logic [$clog2(MAX_VERTICES+1)-1:0] stk_depth
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic          vis_mem [MAX_VERTICES];
    logic [VW-1:0] stk_mem [MAX_VERTICES];
    logic          vis_rdata_reg;
    logic [VW-1:0] stk_rdata_reg;
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] depth_next;
    logic [CW-1:0] top_idx;

    assign top_idx = depth_reg - CW'(1);

    always_comb
    begin
        depth_next = depth_reg;
        if (ctl.push)
        begin
            depth_next = depth_reg + CW'(1);
        end
        else if (ctl.pop)
        begin
            depth_next = depth_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vis_we)
        begin
            vis_mem[vis_addr] <= ctl.vis_wdata;
        end
        vis_rdata_reg <= vis_mem[vis_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stk_mem[depth_reg[VW-1:0]] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[top_idx[VW-1:0]];
    end

    assign vis_rdata = vis_rdata_reg;
    assign stk_rdata = stk_rdata_reg;
    assign stk_depth = depth_reg;

endmodule

// ----- tb/tb_graph_depth_first_traversal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_depth_first_traversal
// Self-checking bench for the depth-first traversal engine. It loads edges,
// clears lists and runs walks under several vertex counts, with directed
// corner requests first and random ones after. A scoreboard keeps its own
// copy of the adjacency tables, predicts every result of each accepted
// request, and checks the result stream in order. Both channels idle in
// short random bursts, the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_graph_depth_first_traversal;
    import gdft_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;
    localparam int ND = MAX_DEGREE_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VTX_W-1:0]    visited_vertex;
        logic                component_end;
        logic                last_result;
    } dfs_result_t;

    class dfs_scoreboard;
        logic [CNT_W-1:0] vertex_count;
        logic [3:0]       list_len[NV];
        logic [VTX_W-1:0] adj[NV][ND];
        dfs_result_t      pending_results[$];
        int               errors;

        function new();
            vertex_count = COUNT_RESET;
            errors = 0;
            foreach (list_len[i])
            begin
                list_len[i] = '0;
            end
        endfunction

        function int unsigned live_count();
            if (vertex_count == 0)
            begin
                return 1;
            end
            if (vertex_count > NV)
            begin
                return NV;
            end
            return vertex_count;
        endfunction

        function dfs_result_t make_result(logic [STATUS_W-1:0] st, logic [VTX_W-1:0] v);
            dfs_result_t r;
            r.status = st;
            r.visited_vertex = v;
            r.component_end = 1'b0;
            r.last_result = 1'b0;
            return r;
        endfunction

        function void walk_graph();
            bit               seen[NV];
            logic [VTX_W-1:0] walk[$];
            logic [VTX_W-1:0] top;
            logic [VTX_W-1:0] nb;
            bit               found;
            int unsigned      n;
            n = live_count();
            foreach (seen[i])
            begin
                seen[i] = 1'b0;
            end
            for (int unsigned v = 0; v < n; v++)
            begin
                if (seen[v])
                begin
                    continue;
                end
                seen[v] = 1'b1;
                walk.delete();
                walk.push_back(VTX_W'(v));
                pending_results.push_back(make_result(ST_VISITED, VTX_W'(v)));
                while (walk.size() > 0)
                begin
                    top = walk[walk.size() - 1];
                    found = 1'b0;
                    for (int j = 0; j < list_len[top]; j++)
                    begin
                        nb = adj[top][j];
                        if (nb < n && !seen[nb])
                        begin
                            seen[nb] = 1'b1;
                            walk.push_back(nb);
                            pending_results.push_back(make_result(ST_VISITED, nb));
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found)
                    begin
                        void'(walk.pop_back());
                    end
                end
                pending_results[pending_results.size() - 1].component_end = 1'b1;
            end
            pending_results[pending_results.size() - 1].last_result = 1'b1;
        endfunction

        function void take_request(logic [MODE_W-1:0] m, logic [VTX_W-1:0] src,
                                   logic [VTX_W-1:0] dst);
            dfs_result_t r;
            int unsigned n;
            n = live_count();
            case (m)
                MODE_ADD:
                begin
                    if (src >= n || dst >= n)
                    begin
                        r = make_result(ST_RANGE, '0);
                    end
                    else if (list_len[src] >= ND)
                    begin
                        r = make_result(ST_FULL, '0);
                    end
                    else
                    begin
                        adj[src][list_len[src]] = dst;
                        list_len[src] = list_len[src] + 1;
                        r = make_result(ST_STORED, '0);
                    end
                    r.last_result = 1'b1;
                    pending_results.push_back(r);
                end
                MODE_RUN:
                begin
                    walk_graph();
                end
                MODE_CLEAR:
                begin
                    foreach (list_len[i])
                    begin
                        list_len[i] = '0;
                    end
                    r = make_result(ST_CLEARED, '0);
                    r.last_result = 1'b1;
                    pending_results.push_back(r);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, int exp_v, int got_v);
            if (exp_v != got_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
            end
        endfunction

        function void check_result(dfs_result_t got);
            dfs_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %0d vertex %0d",
                         $time, "actual status", got.status, got.visited_vertex);
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("status", exp_r.status, got.status);
            compare_field("visited_vertex", exp_r.visited_vertex, got.visited_vertex);
            compare_field("component_end", exp_r.component_end, got.component_end);
            compare_field("last_result", exp_r.last_result, got.last_result);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    gdft_req_if req_if();
    gdft_rsp_if rsp_if();

    dfs_scoreboard sb;
    bit            calm;
    bit            long_hold_req;

    graph_depth_first_traversal dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always #5 clk = ~clk;

    initial
    begin
        #100ms;
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [VTX_W-1:0] src,
                                input logic [VTX_W-1:0] dst);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= m;
        req_if.source_vertex <= src;
        req_if.target_vertex <= dst;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        sb.take_request(m, src, dst);
    endtask

    // drain all results, then let the engine go quiet
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.vertex_count = value;
    endtask

    task automatic random_phase(input logic [CNT_W-1:0] cnt, input int n_items);
        int unsigned      pick;
        int unsigned      live;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
        settle();
        write_vertex_count(cnt);
        live = sb.live_count();
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            src = VTX_W'($urandom_range(0, live - 1));
            dst = VTX_W'($urandom_range(0, live - 1));
            if (pick < 5)
            begin
                send_request(MODE_RUN, VTX_W'($urandom), VTX_W'($urandom));
            end
            else if (pick < 8)
            begin
                send_request(MODE_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
            end
            else if (pick < 10)
            begin
                send_request(MODE_UNUSED, VTX_W'($urandom), VTX_W'($urandom));
            end
            else if (pick < 30)
            begin
                // chains make for deep walks
                send_request(MODE_ADD, src, VTX_W'((src + 1) % live));
            end
            else if (pick < 88)
            begin
                send_request(MODE_ADD, src, dst);
            end
            else
            begin
                send_request(MODE_ADD, VTX_W'($urandom), VTX_W'($urandom));
            end
        end
        send_request(MODE_RUN, VTX_W'($urandom), VTX_W'($urandom));
    endtask

    // receiver: checks results, idles in bursts, one long hold-off on request
    initial
    begin
        int          stall_left;
        dfs_result_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.status         = rsp_if.status;
                got.visited_vertex = rsp_if.visited_vertex;
                got.component_end  = rsp_if.component_end;
                got.last_result    = rsp_if.last_result;
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = 400;
                rsp_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int drain_cycles;
        sb = new();
        calm = 1'b0;
        long_hold_req = 1'b0;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_ADD;
        req_if.source_vertex = '0;
        req_if.target_vertex = '0;
        rsp_if.ready = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_vertex_count(COUNT_RESET);

        // directed: extremes, full list, unused mode, count floor and ceiling
        send_request(MODE_CLEAR, 6'd63, 6'd63);
        send_request(MODE_ADD, 6'd0, 6'd63);
        send_request(MODE_ADD, 6'd63, 6'd0);
        send_request(MODE_ADD, 6'd63, 6'd63);
        for (int k = 0; k <= ND; k++)
        begin
            send_request(MODE_ADD, 6'd1, VTX_W'(k));
        end
        send_request(MODE_UNUSED, 6'd63, 6'd63);
        send_request(MODE_RUN, 6'd0, 6'd0);
        settle();
        write_vertex_count(7'd0);
        send_request(MODE_ADD, 6'd0, 6'd1);
        send_request(MODE_ADD, 6'd1, 6'd0);
        send_request(MODE_ADD, 6'd0, 6'd0);
        send_request(MODE_RUN, 6'd0, 6'd0);
        settle();
        write_vertex_count(7'd4);
        send_request(MODE_ADD, 6'd4, 6'd0);
        send_request(MODE_RUN, 6'd0, 6'd0);
        settle();
        write_vertex_count(7'd127);
        send_request(MODE_ADD, 6'd63, 6'd62);
        send_request(MODE_RUN, 6'd0, 6'd0);

        random_phase(7'd2, 45);
        random_phase(7'd7, 45);
        long_hold_req = 1'b1;
        random_phase(7'd16, 45);
        random_phase(7'd64, 45);
        random_phase(7'd1, 45);
        random_phase(7'd33, 45);
        random_phase(7'd100, 45);
        random_phase(7'd12, 45);
        calm = 1'b1;
        random_phase(7'd64, 45);
        random_phase(7'd127, 45);

        req_if.valid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 200000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (100) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
